>>> src/rsa_me_pkg.sv
// Package with shared widths, register indexes, reset values and unit status type.
`timescale 1ns / 1ps
package rsa_me_pkg;

    localparam int FIELD_W          = 62;
    localparam int TDATA_W          = ((FIELD_W + 7) / 8) * 8;
    localparam int MOD_BITS_DEFAULT = 62;
    localparam int CFG_IDX_W        = 8;

    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

    localparam logic [FIELD_W-1:0] EXPONENT_RESET = FIELD_W'(3);
    localparam logic [FIELD_W-1:0] MODULUS_RESET  = FIELD_W'(3);

    // Status of the modular multiplier as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

>>> src/rsa_me_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, shift-and-add doubling.
`timescale 1ns / 1ps
module rsa_me_mulmod #(
    parameter int MOD_BITS = rsa_me_pkg::MOD_BITS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [MOD_BITS-1:0]     x,
    input  logic [MOD_BITS-1:0]     y,
    input  logic [MOD_BITS-1:0]     n,
    output logic [MOD_BITS-1:0]     product,
    output rsa_me_pkg::mm_status_t  status
);
    import rsa_me_pkg::*;

    logic [MOD_BITS-1:0] acc_reg;
    logic [MOD_BITS-1:0] addend_reg;
    logic [MOD_BITS-1:0] y_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [MOD_BITS:0]   n_ext;
    logic [MOD_BITS:0]   sum;
    logic [MOD_BITS:0]   dbl;
    logic [MOD_BITS-1:0] acc_next;
    logic [MOD_BITS-1:0] addend_next;

    // Both operands stay below n, so one conditional subtraction suffices.
    always_comb begin
        n_ext       = {1'b0, n};
        sum         = {1'b0, acc_reg} + {1'b0, addend_reg};
        dbl         = {addend_reg, 1'b0};
        acc_next    = (sum >= n_ext) ? MOD_BITS'(sum - n_ext) : sum[MOD_BITS-1:0];
        addend_next = (dbl >= n_ext) ? MOD_BITS'(dbl - n_ext) : dbl[MOD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (y_reg == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && start) begin
            acc_reg    <= '0;
            addend_reg <= x;
            y_reg      <= y;
        end else if (busy_reg && (y_reg != '0)) begin
            if (y_reg[0]) begin
                acc_reg <= acc_next;
            end
            addend_reg <= addend_next;
            y_reg      <= y_reg >> 1;
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("multiplier reports done while still busy");
    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (y_reg == '0)) |=> done_reg)
        else $error("multiplier did not finish after its last multiplier bit");
    a_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        (!busy_reg && start) |=> (busy_reg && !done_reg))
        else $error("multiplier did not start on request");
`endif

endmodule

>>> src/rsa_modular_exponentiation.sv
// Top level: modular exponentiation of one message word per beat with a key from configuration.
`timescale 1ns / 1ps
// Computes message^exponent mod modulus for each input beat, with exponent and modulus
// written over the configuration channel (index 0 exponent, index 1 modulus, others
// ignored). One word is processed at a time. The message is first reduced bit-serially;
// then the exponent is scanned from its low bit, each bit costing a square and, for a
// one bit, a multiply on the shared bit-serial modular multiplier. A product takes longer
// the longer the bit length of its multiplier, and a small exponent finishes sooner than
// a large one. The result waits in an output register so the next beat can be accepted
// before it is taken. out_of_range flags a message not below the modulus; a modulus
// below two yields a zero result.
module rsa_modular_exponentiation #(
    parameter int MOD_BITS = rsa_me_pkg::MOD_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata fields from bit 0: message[61:0], zero padding
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rsa_me_pkg::TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    // m_tdata fields from bit 0: result[61:0], zero padding
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rsa_me_pkg::TDATA_W-1:0]    m_tdata,
    // m_tuser fields from bit 0: out_of_range
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rsa_me_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsa_me_pkg::FIELD_W-1:0]    cfg_data
);
    import rsa_me_pkg::*;

    localparam int CNT_W = $clog2(MOD_BITS);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_EXP    = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_SQR    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t              state_reg;
    logic [FIELD_W-1:0]  exponent_reg;
    logic [FIELD_W-1:0]  modulus_reg;

    logic [MOD_BITS-1:0] msg_sh_reg;
    logic [MOD_BITS-1:0] base_reg;
    logic [MOD_BITS-1:0] acc_reg;
    logic [MOD_BITS-1:0] e_sh_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                oor_reg;
    logic                last_reg;

    logic                m_valid_reg;
    logic [FIELD_W-1:0]  m_result_reg;
    logic                m_oor_reg;
    logic                m_last_reg;

    logic [MOD_BITS+FIELD_W-1:0] msg_ext;
    logic [MOD_BITS+FIELD_W-1:0] exp_ext;
    logic [MOD_BITS+FIELD_W-1:0] mod_ext;
    logic [MOD_BITS+FIELD_W-1:0] res_ext;
    logic [MOD_BITS-1:0] msg_mb;
    logic [MOD_BITS-1:0] exp_mb;
    logic [MOD_BITS-1:0] mod_mb;
    logic [MOD_BITS:0]   red_t;
    logic [MOD_BITS-1:0] base_next;

    logic                s_accept;
    logic                out_load;
    logic                mm_start;
    logic [MOD_BITS-1:0] mm_x;
    logic [MOD_BITS-1:0] mm_product;
    mm_status_t          mm_status;

    // Field bits above MOD_BITS are dropped; a datapath wider than a field pads with zeros.
    always_comb begin
        msg_ext = {{MOD_BITS{1'b0}}, s_tdata[FIELD_W-1:0]};
        exp_ext = {{MOD_BITS{1'b0}}, exponent_reg};
        mod_ext = {{MOD_BITS{1'b0}}, modulus_reg};
        res_ext = {{FIELD_W{1'b0}}, acc_reg};
        msg_mb  = msg_ext[MOD_BITS-1:0];
        exp_mb  = exp_ext[MOD_BITS-1:0];
        mod_mb  = mod_ext[MOD_BITS-1:0];
    end

    // Restoring reduction: shift in one message bit, subtract the modulus once if reached.
    always_comb begin
        red_t     = {base_reg, msg_sh_reg[MOD_BITS-1]};
        base_next = (red_t >= {1'b0, mod_mb}) ? MOD_BITS'(red_t - {1'b0, mod_mb})
                                              : red_t[MOD_BITS-1:0];
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    assign mm_start = ((state_reg == ST_EXP) && (e_sh_reg != '0))
                   || ((state_reg == ST_MUL) && mm_status.done);
    assign mm_x     = ((state_reg == ST_EXP) && e_sh_reg[0]) ? acc_reg : base_reg;

    rsa_me_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .x       (mm_x),
        .y       (base_reg),
        .n       (mod_mb),
        .product (mm_product),
        .status  (mm_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg <= EXPONENT_RESET;
            modulus_reg  <= MODULUS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_EXPONENT: exponent_reg <= cfg_data;
                REG_MODULUS:  modulus_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= (mod_mb < MOD_BITS'(2)) ? ST_FINISH : ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_EXP;
                    end
                end
                ST_EXP: begin
                    if (e_sh_reg == '0) begin
                        state_reg <= ST_FINISH;
                    end else if (e_sh_reg[0]) begin
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_SQR;
                    end
                end
                ST_MUL: begin
                    if (mm_status.done) begin
                        state_reg <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (mm_status.done) begin
                        state_reg <= ST_EXP;
                    end
                end
                ST_FINISH: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    msg_sh_reg <= msg_mb;
                    base_reg   <= '0;
                    acc_reg    <= '0;
                    cnt_reg    <= CNT_W'(MOD_BITS - 1);
                    oor_reg    <= (msg_mb >= mod_mb);
                    last_reg   <= s_tlast;
                end
            end
            ST_REDUCE: begin
                base_reg   <= base_next;
                msg_sh_reg <= msg_sh_reg << 1;
                cnt_reg    <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    acc_reg  <= MOD_BITS'(1);
                    e_sh_reg <= exp_mb;
                end
            end
            ST_MUL: begin
                if (mm_status.done) begin
                    acc_reg <= mm_product;
                end
            end
            ST_SQR: begin
                if (mm_status.done) begin
                    base_reg <= mm_product;
                    e_sh_reg <= e_sh_reg >> 1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_result_reg <= res_ext[FIELD_W-1:0];
            m_oor_reg    <= oor_reg;
            m_last_reg   <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - FIELD_W){1'b0}}, m_result_reg};
    assign m_tuser  = m_oor_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_mm_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_start |-> !mm_status.busy)
        else $error("multiplier started while busy");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("second beat accepted while a word is in progress");
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_tvalid && (state_reg == ST_IDLE)))
        else $error("finished result not presented on the output");
`endif

endmodule
